// ===== design/rwl_pkg.sv =====
// ----------------------------------------------------------------------------
// rwl_pkg: shared types and constants for the readers-writer lock arbiter
// Queue depths, field widths, request and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rwl_pkg;

  localparam int MAX_READERS = 8;
  localparam int MAX_WRITERS = 8;

  localparam int KIND_W   = 2;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;

  // counts hold 0..MAX, indexes 0..MAX-1
  localparam int RD_CNT_W = $clog2(MAX_READERS + 1);
  localparam int RD_IDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int WR_CNT_W = $clog2(MAX_WRITERS + 1);
  localparam int WR_IDX_W = (MAX_WRITERS > 1) ? $clog2(MAX_WRITERS) : 1;

  typedef enum logic [KIND_W-1:0] {
    K_START_READ  = 2'd0,
    K_END_READ    = 2'd1,
    K_START_WRITE = 2'd2,
    K_END_WRITE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_READ     = 3'd1,
    ST_WRITE    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_ERROR    = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the incoming request word
    logic answer;  // answer the caller and update lock state
    logic wake_w;  // grant the oldest waiting writer
    logic wake_r;  // grant the next waiting reader
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic follow_w;       // the answer is followed by a writer grant
    logic follow_r;       // the answer is followed by a reader cascade
    logic r_last;         // current cascade grant is the final one
    logic writer_active;
    logic readers_zero;
  } sts_t;

endpackage

// ===== design/rwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwl_ctrl: sequencer for the readers-writer lock arbiter
// Steps one request through its answer and any wake-up grants that follow.
// ----------------------------------------------------------------------------
module rwl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rwl_pkg::sts_t sts,
  output rwl_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ANSWER,
    S_WAKE_W,
    S_WAKE_R
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = S_ANSWER;
        end
      end
      S_ANSWER: begin
        cmd.answer = 1'b1;
        if (sts.follow_w) begin
          state_nxt = S_WAKE_W;
        end else if (sts.follow_r) begin
          state_nxt = S_WAKE_R;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WAKE_W: begin
        cmd.wake_w = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_WAKE_R: begin
        cmd.wake_r = 1'b1;
        if (sts.r_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== design/rwl_datapath.sv =====
// ----------------------------------------------------------------------------
// rwl_datapath: lock state, wait queues and result register
// Holds the reader count, writer flag, reader and writer FIFOs, and builds
// each result word on command from the controller.
// ----------------------------------------------------------------------------
module rwl_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rwl_pkg::cmd_t                 cmd,
  input  logic [rwl_pkg::KIND_W-1:0]    in_kind,
  input  logic [rwl_pkg::REQ_W-1:0]     in_requester,
  output rwl_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic [rwl_pkg::REQ_W-1:0]     out_who,
  output logic [rwl_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  localparam int RCW = rwl_pkg::RD_CNT_W;
  localparam int RIW = rwl_pkg::RD_IDX_W;
  localparam int WCW = rwl_pkg::WR_CNT_W;
  localparam int WIW = rwl_pkg::WR_IDX_W;

  typedef enum logic [1:0] {
    WHO_REQ,
    WHO_WQ,
    WHO_RQ
  } who_sel_t;

  // request word
  rwl_pkg::kind_t             kind_r;
  logic [rwl_pkg::REQ_W-1:0]  req_r;

  // lock state
  logic [RCW-1:0] ar_r, ar_nxt;
  logic           wa_r, wa_nxt;

  // reader wait queue: linear fill, drained in order by the cascade
  logic [rwl_pkg::REQ_W-1:0] rq_mem [rwl_pkg::MAX_READERS];
  logic [RCW-1:0] rq_cnt_r, rq_cnt_nxt;
  logic [RIW-1:0] ridx_r, ridx_nxt;
  logic           rq_push;

  // writer wait queue: circular FIFO
  logic [rwl_pkg::REQ_W-1:0] wq_mem [rwl_pkg::MAX_WRITERS];
  logic [WIW-1:0] wq_head_r, wq_head_nxt;
  logic [WIW-1:0] wq_tail_r, wq_tail_nxt;
  logic [WCW-1:0] wq_cnt_r, wq_cnt_nxt;
  logic           wq_push;

  // result word
  logic                    res_valid;
  rwl_pkg::status_t        res_status;
  logic                    res_last;
  who_sel_t                who_sel;
  logic                    out_valid_r;
  logic [rwl_pkg::REQ_W-1:0] out_who_r;
  rwl_pkg::status_t        out_status_r;
  logic                    out_last_r;

  // decisions for the answer step
  rwl_pkg::status_t ans_status;
  logic             follow_w;
  logic             follow_r;
  logic             r_last;

  function automatic logic [WIW-1:0] wq_inc(input logic [WIW-1:0] p);
    logic [WIW-1:0] q;
    if (p == WIW'(rwl_pkg::MAX_WRITERS - 1)) begin
      q = '0;
    end else begin
      q = p + WIW'(1);
    end
    return q;
  endfunction

  assign r_last = ((RCW'(ridx_r) + RCW'(1)) == rq_cnt_r);

  always_comb begin
    ans_status = rwl_pkg::ST_ERROR;
    follow_w   = 1'b0;
    follow_r   = 1'b0;
    case (kind_r)
      rwl_pkg::K_START_READ: begin
        if (wa_r) begin
          if (rq_cnt_r < RCW'(rwl_pkg::MAX_READERS)) begin
            ans_status = rwl_pkg::ST_QUEUED;
          end
        end else if (ar_r < RCW'(rwl_pkg::MAX_READERS)) begin
          ans_status = rwl_pkg::ST_READ;
        end
      end
      rwl_pkg::K_END_READ: begin
        if (ar_r != '0) begin
          ans_status = rwl_pkg::ST_RELEASED;
          // last reader out hands the lock to the oldest writer
          follow_w   = (ar_r == RCW'(1)) && !wa_r && (wq_cnt_r != '0);
        end
      end
      rwl_pkg::K_START_WRITE: begin
        if ((ar_r != '0) || wa_r) begin
          if (wq_cnt_r < WCW'(rwl_pkg::MAX_WRITERS)) begin
            ans_status = rwl_pkg::ST_QUEUED;
          end
        end else begin
          ans_status = rwl_pkg::ST_WRITE;
        end
      end
      rwl_pkg::K_END_WRITE: begin
        if (wa_r) begin
          ans_status = rwl_pkg::ST_RELEASED;
          // waiting readers take priority over waiting writers
          follow_r   = (rq_cnt_r != '0);
          follow_w   = (rq_cnt_r == '0) && (wq_cnt_r != '0);
        end
      end
      default: begin
        ans_status = rwl_pkg::ST_ERROR;
      end
    endcase
  end

  always_comb begin
    ar_nxt      = ar_r;
    wa_nxt      = wa_r;
    rq_cnt_nxt  = rq_cnt_r;
    ridx_nxt    = ridx_r;
    rq_push     = 1'b0;
    wq_head_nxt = wq_head_r;
    wq_tail_nxt = wq_tail_r;
    wq_cnt_nxt  = wq_cnt_r;
    wq_push     = 1'b0;
    res_valid   = 1'b0;
    res_status  = ans_status;
    res_last    = 1'b1;
    who_sel     = WHO_REQ;

    if (cmd.answer) begin
      res_valid = 1'b1;
      res_last  = !(follow_w || follow_r);
      case (kind_r)
        rwl_pkg::K_START_READ: begin
          if (ans_status == rwl_pkg::ST_QUEUED) begin
            rq_push    = 1'b1;
            rq_cnt_nxt = rq_cnt_r + RCW'(1);
          end else if (ans_status == rwl_pkg::ST_READ) begin
            ar_nxt = ar_r + RCW'(1);
          end
        end
        rwl_pkg::K_END_READ: begin
          if (ans_status == rwl_pkg::ST_RELEASED) begin
            ar_nxt = ar_r - RCW'(1);
          end
        end
        rwl_pkg::K_START_WRITE: begin
          if (ans_status == rwl_pkg::ST_QUEUED) begin
            wq_push     = 1'b1;
            wq_tail_nxt = wq_inc(wq_tail_r);
            wq_cnt_nxt  = wq_cnt_r + WCW'(1);
          end else if (ans_status == rwl_pkg::ST_WRITE) begin
            wa_nxt = 1'b1;
          end
        end
        rwl_pkg::K_END_WRITE: begin
          if (ans_status == rwl_pkg::ST_RELEASED) begin
            wa_nxt = 1'b0;
          end
        end
        default: begin
          ar_nxt = ar_r;
        end
      endcase
    end else if (cmd.wake_w) begin
      res_valid   = 1'b1;
      res_status  = rwl_pkg::ST_WRITE;
      who_sel     = WHO_WQ;
      wa_nxt      = 1'b1;
      wq_head_nxt = wq_inc(wq_head_r);
      wq_cnt_nxt  = wq_cnt_r - WCW'(1);
    end else if (cmd.wake_r) begin
      res_valid  = 1'b1;
      res_status = rwl_pkg::ST_READ;
      res_last   = r_last;
      who_sel    = WHO_RQ;
      ar_nxt     = ar_r + RCW'(1);
      if (r_last) begin
        ridx_nxt   = '0;
        rq_cnt_nxt = '0;
      end else begin
        ridx_nxt = ridx_r + RIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ar_r        <= '0;
      wa_r        <= 1'b0;
      rq_cnt_r    <= '0;
      ridx_r      <= '0;
      wq_head_r   <= '0;
      wq_tail_r   <= '0;
      wq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ar_r        <= ar_nxt;
      wa_r        <= wa_nxt;
      rq_cnt_r    <= rq_cnt_nxt;
      ridx_r      <= ridx_nxt;
      wq_head_r   <= wq_head_nxt;
      wq_tail_r   <= wq_tail_nxt;
      wq_cnt_r    <= wq_cnt_nxt;
      out_valid_r <= res_valid;
    end
  end

  // payload: request capture, queue writes and the result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= rwl_pkg::kind_t'(in_kind);
      req_r  <= in_requester;
    end
    if (rq_push) begin
      rq_mem[rq_cnt_r[RIW-1:0]] <= req_r;
    end
    if (wq_push) begin
      wq_mem[wq_tail_r] <= req_r;
    end
    if (res_valid) begin
      out_status_r <= res_status;
      out_last_r   <= res_last;
      case (who_sel)
        WHO_WQ:  out_who_r <= wq_mem[wq_head_r];
        WHO_RQ:  out_who_r <= rq_mem[ridx_r];
        default: out_who_r <= req_r;
      endcase
    end
  end

  assign sts.follow_w      = follow_w;
  assign sts.follow_r      = follow_r;
  assign sts.r_last        = r_last;
  assign sts.writer_active = wa_r;
  assign sts.readers_zero  = (ar_r == '0);

  assign out_valid  = out_valid_r;
  assign out_who    = out_who_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== design/readers_writer_lock_arbiter_core.sv =====
// ----------------------------------------------------------------------------
// readers_writer_lock_arbiter_core: reader-preference readers-writer lock
// Takes start/end read/write requests and reports queue, grant and release
// results, including grants to woken waiters.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_kind / in_requester with start high; the word is
//   taken at an edge where start is high and busy is low. busy stays high
//   until every result of that request has been issued.
//   Result channel: each result word is on out_who / out_status / out_last for
//   one cycle with out_valid high. out_last marks the final word of a request.
//   The receiver cannot stall; results are never held back.
//   Timing: the caller's answer is registered after the request word is captured
//   at the accept edge. A request that wakes a writer adds one grant word; an end
//   write that wakes N waiting readers (N up to MAX_READERS) adds N grant words,
//   one grant per cycle from the reader FIFO, stepped out by the controller.
//   A new request can be taken in the cycle the last result is shown.
//   Reset (rst_n low, synchronous) empties both queues, clears the reader
//   count and writer flag and drops out_valid.
// ----------------------------------------------------------------------------
module readers_writer_lock_arbiter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rwl_pkg::KIND_W-1:0]    in_kind,
  input  logic [rwl_pkg::REQ_W-1:0]     in_requester,
  output logic                          out_valid,
  output logic [rwl_pkg::REQ_W-1:0]     out_who,
  output logic [rwl_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  rwl_pkg::cmd_t cmd;
  rwl_pkg::sts_t sts;

  rwl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rwl_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_kind      (in_kind),
    .in_requester (in_requester),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_who      (out_who),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  // a writer never holds the lock alongside readers
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.writer_active && !sts.readers_zero))
    else $error("writer and readers hold the lock together");

  // results only come out of an active request
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a request in flight");

  // every accepted request is answered once its request word and result word are registered
  a_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request not answered on time");

  // wake-up grants follow back to back until the last word
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a result burst");

endmodule
